[rtl/nsc_pkg.sv]
// types, character codes and tag lookup for the nmea sentence checker
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

	localparam int CHAR_W  = 7;
	localparam int ACC_W   = 12;
	localparam int MATCH_W = 3;
	localparam int TERM_W  = 5;
	localparam int TCHAR_W = 4;
	localparam int COUNT_W = 7;

	localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 7'h24;
	localparam logic [CHAR_W-1:0] CH_STAR   = 7'h2A;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 7'h2C;
	localparam logic [CHAR_W-1:0] CH_HEX_A  = 7'd65;

	localparam logic [ACC_W-1:0] HEX_OFS_LETTER = 12'd55;
	localparam logic [ACC_W-1:0] HEX_OFS_DIGIT  = 12'd48;

	// tag positions 1..6 after the dollar
	localparam logic [COUNT_W-1:0] TAG_END     = 7'd7;
	localparam logic [MATCH_W-1:0] TAG_MATCHES = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_CK1  = 2'd2,
		PH_CK2  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [ACC_W-1:0]    accum;
		logic [MATCH_W-1:0]  tag_hits;
		logic [TERM_W-1:0]   term_index;
		logic [TCHAR_W-1:0]  term_chars;
		logic [COUNT_W-1:0]  char_count;
	} state_t;

	typedef struct packed {
		logic                accepted;
		logic                is_gprmc;
		logic [TERM_W-1:0]   term_total;
		logic [COUNT_W-1:0]  sentence_length;
	} result_t;

	function automatic logic [CHAR_W-1:0] tag_char(input logic [2:0] pos);
		logic [CHAR_W-1:0] ch;
		case (pos)
			3'd1:    ch = 7'h47;
			3'd2:    ch = 7'h50;
			3'd3:    ch = 7'h52;
			3'd4:    ch = 7'h4D;
			3'd5:    ch = 7'h43;
			3'd6:    ch = CH_COMMA;
			default: ch = CH_DOLLAR;
		endcase
		return ch;
	endfunction

	// untrapped hex digit value, modulo 2^12
	function automatic logic [ACC_W-1:0] hex_value(input logic [CHAR_W-1:0] ch);
		logic [ACC_W-1:0] wide;
		wide = {{(ACC_W-CHAR_W){1'b0}}, ch};
		return (ch >= CH_HEX_A) ? wide - HEX_OFS_LETTER : wide - HEX_OFS_DIGIT;
	endfunction

endpackage

`default_nettype wire

[rtl/nsc_intf.sv]
// handshake channel interfaces: characters, results and configuration
`timescale 1ns / 1ps
`default_nettype none

interface nsc_char_if
	import nsc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

interface nsc_result_if
	import nsc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               is_gprmc;
	logic [TERM_W-1:0]  term_total;
	logic [COUNT_W-1:0] sentence_length;

	modport source(output valid, output accepted, output is_gprmc, output term_total,
		output sentence_length, input ready);
	modport sink(input valid, input accepted, input is_gprmc, input term_total,
		input sentence_length, output ready);
endinterface

interface nsc_cfg_if;
	logic valid;
	logic ready;
	logic gprmc_only;

	modport source(output valid, output gprmc_only, input ready);
	modport sink(input valid, input gprmc_only, output ready);
endinterface

`default_nettype wire

[rtl/nsc_step.sv]
// per-character sentence tracking: next state and result from one character
`timescale 1ns / 1ps
`default_nettype none

module nsc_step
	import nsc_pkg::*;
#(
	parameter int MAX_SENTENCE = 100,
	parameter int MAX_TERMS    = 30,
	parameter int MAX_TERM_LEN = 15
) (
	input  state_t            cur,
	input  logic [CHAR_W-1:0] ch,
	input  logic              gprmc_only,
	output state_t            nxt,
	output result_t           res
);

	localparam logic [COUNT_W-1:0] LIM_COUNT = COUNT_W'(MAX_SENTENCE);
	localparam logic [TERM_W-1:0]  LIM_TERMS = TERM_W'(MAX_TERMS);
	localparam logic [TCHAR_W-1:0] LIM_TLEN  = TCHAR_W'(MAX_TERM_LEN);

	phase_t           phase;
	logic [ACC_W-1:0] hex;
	logic [ACC_W-1:0] acc_final;
	logic [ACC_W-1:0] ch_wide;

	assign hex     = hex_value(ch);
	assign ch_wide = {{(ACC_W-CHAR_W){1'b0}}, ch};

	always_comb begin
		phase = cur.phase;
		if (cur.char_count >= LIM_COUNT || cur.term_index >= LIM_TERMS
				|| cur.term_chars >= LIM_TLEN)
			phase = PH_IDLE;
		if (ch == CH_LF || ch == CH_CR)
			phase = PH_IDLE;

		nxt       = cur;
		nxt.phase = phase;
		res       = '0;
		acc_final = cur.accum - hex;

		if (ch == CH_DOLLAR) begin
			nxt.phase      = PH_BODY;
			nxt.accum      = '0;
			nxt.tag_hits   = '0;
			nxt.term_index = '0;
			nxt.term_chars = '0;
			nxt.char_count = COUNT_W'(1);
		end else begin
			case (phase)
				PH_BODY: begin
					if (cur.char_count < TAG_END && ch == tag_char(cur.char_count[2:0]))
						nxt.tag_hits = cur.tag_hits + MATCH_W'(1);
					nxt.char_count = cur.char_count + COUNT_W'(1);
					if (ch == CH_COMMA) begin
						nxt.term_index = cur.term_index + TERM_W'(1);
						nxt.term_chars = '0;
						nxt.accum      = cur.accum ^ ch_wide;
					end else if (ch == CH_STAR) begin
						nxt.term_index = cur.term_index + TERM_W'(1);
						nxt.term_chars = '0;
						nxt.phase      = PH_CK1;
					end else begin
						nxt.term_chars = cur.term_chars + TCHAR_W'(1);
						nxt.accum      = cur.accum ^ ch_wide;
					end
				end
				PH_CK1: begin
					nxt.char_count = cur.char_count + COUNT_W'(1);
					nxt.term_chars = cur.term_chars + TCHAR_W'(1);
					nxt.accum      = cur.accum - {hex[ACC_W-5:0], 4'b0000};
					nxt.phase      = PH_CK2;
				end
				PH_CK2: begin
					nxt.char_count = cur.char_count + COUNT_W'(1);
					nxt.term_chars = cur.term_chars + TCHAR_W'(1);
					nxt.term_index = cur.term_index + TERM_W'(1);
					nxt.accum      = acc_final;
					nxt.phase      = PH_IDLE;
					if (acc_final == '0 && (!gprmc_only || cur.tag_hits == TAG_MATCHES)) begin
						res.accepted        = 1'b1;
						res.is_gprmc        = (cur.tag_hits == TAG_MATCHES);
						res.term_total      = nxt.term_index;
						res.sentence_length = nxt.char_count;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// datapath: a character is taken into an input register (char_s1) and its result is registered
//   in the result register (out_q), from which the result is offered
// throughput: one character per cycle, the sentence state updates as each character leaves
//   the input register for the result register; a stalled result holds the input register
// reset: arst_n clears the parse state, the filter bit and both valid flags at once
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checker
	import nsc_pkg::*;
#(
	parameter int MAX_SENTENCE = 100,
	parameter int MAX_TERMS    = 30,
	parameter int MAX_TERM_LEN = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	nsc_char_if.sink      chars,
	nsc_cfg_if.sink       cfg,
	nsc_result_if.source  results
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_valid_q;
	result_t           out_q;
	state_t            state_q;
	state_t            state_nxt;
	result_t           res_nxt;
	logic              gprmc_only_q;
	logic              advance;

	// input register moves on when the result register is free or being emptied
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	nsc_step #(
		.MAX_SENTENCE (MAX_SENTENCE),
		.MAX_TERMS    (MAX_TERMS),
		.MAX_TERM_LEN (MAX_TERM_LEN)
	) u_step (
		.cur        (state_q),
		.ch         (char_s1),
		.gprmc_only (gprmc_only_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gprmc_only_q <= 1'b0;
		end else if (cfg.valid) begin
			gprmc_only_q <= cfg.gprmc_only;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready)
			char_s1 <= chars.char_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: PH_IDLE, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res_nxt;
	end

	assign results.valid           = out_valid_q;
	assign results.accepted        = out_q.accepted;
	assign results.is_gprmc        = out_q.is_gprmc;
	assign results.term_total      = out_q.term_total;
	assign results.sentence_length = out_q.sentence_length;

	// an accepted sentence holds at least dollar, star and two digits over two terms
	a_accept_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.accepted |-> out_q.sentence_length >= COUNT_W'(4)
			&& out_q.term_total >= TERM_W'(2))
		else $error("accepted sentence shorter than minimum");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.accepted |-> !out_q.is_gprmc && out_q.term_total == '0
			&& out_q.sentence_length == '0)
		else $error("rejected result carries nonzero fields");

	// a completed sentence leaves the parser waiting for a dollar
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.accepted |-> state_q.phase == PH_IDLE)
		else $error("parser not idle after accepted sentence");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && out_valid_q && !results.ready)
		else $error("input stalled without a blocked result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("parse state changed without a request moving on");

	a_filter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.accepted && gprmc_only_q |-> out_q.is_gprmc)
		else $error("filtered acceptance without gprmc tag");

endmodule

`default_nettype wire
